/* rtl/vrr_pkg.sv */
package vrr_pkg;

    localparam int MAX_REPLY_BYTES = 16;
    localparam int CNT_W = $clog2(MAX_REPLY_BYTES + 1);
    localparam int LEN_W = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] HDR_BYTE = 8'h90;
    localparam logic [7:0] END_BYTE = 8'hFF;
    localparam logic [7:0] TYPE_INFO = 8'h50;
    localparam logic [3:0] HI_ACK = 4'h4;
    localparam logic [3:0] HI_COMPLETION = 4'h5;
    localparam logic [3:0] HI_ERROR = 4'h6;
    localparam logic [7:0] ERR_CANCEL_A = 8'h04;
    localparam logic [7:0] ERR_CANCEL_B = 8'h05;
    localparam logic [3:0] SOCK_ONE = 4'h1;
    localparam logic [3:0] SOCK_TWO = 4'h2;
    localparam logic [LEN_W-1:0] LEN_SHORT = 5'd3;
    localparam logic [LEN_W-1:0] LEN_CANCEL = 5'd4;

    typedef enum logic [2:0] {
        KIND_ACK        = 3'd0,
        KIND_COMPLETION = 3'd1,
        KIND_INFO       = 3'd2,
        KIND_ERROR      = 3'd3,
        KIND_OTHER      = 3'd4,
        KIND_OVERLONG   = 3'd5
    } kind_t;

    typedef struct packed {
        logic             has_type;
        logic             overlong;
        logic [LEN_W-1:0] len;
        logic [7:0]       type_byte;
        logic [7:0]       third_byte;
        logic [15:0]      value_one;
        logic [15:0]      value_two;
    } frame_t;

    typedef struct packed {
        kind_t            kind;
        logic [3:0]       sock;
        logic [LEN_W-1:0] len;
        logic [7:0]       error_byte;
        logic [15:0]      value_one;
        logic [15:0]      value_two;
        logic [1:0]       busy;
    } result_t;

endpackage

/* rtl/visca_reply_receiver.sv */
// Camera reply deframer.
// Input queue side: rx_byte is taken on a clock edge with push high and full
// low, one beat per received byte, one beat per cycle at full rate.
// Result queue side: while empty is low the oldest reply sits on reply_kind,
// socket_number, reply_length, error_byte, first_value, second_value and the
// two socket busy flags; it leaves on an edge with pop high.
// Only the terminator byte of a packet yields a result. Its result reaches
// the ports through registers: the frame enters the frame queue on the
// terminator edge itself, and the reply classifier, which also holds the
// socket pending flags, moves it into the output stage while its skid
// entry is free. Every other byte is absorbed with no result.
// The framer and classifier are joined by a two-entry frame queue, and the
// classifier drives a two-entry output stage, so a stalled result side holds
// up to four replies before full rises; once the frame queue is full, every
// byte waits, terminator or not. Sustained rate, while full is low, is one
// byte per cycle. Reset clears the framer to header hunt, empties both queues
// and clears the socket pending flags.
module visca_reply_receiver
    import vrr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic [2:0]        reply_kind,
    output logic [3:0]        socket_number,
    output logic [LEN_W-1:0]  reply_length,
    output logic [7:0]        error_byte,
    output logic [15:0]       first_value,
    output logic [15:0]       second_value,
    output logic              socket_one_busy,
    output logic              socket_two_busy
);

    logic    accept;
    logic    frame_push;
    frame_t  frame_in;
    frame_t  frame_out;
    logic    frame_valid;
    logic    frame_take;
    logic    head_valid;
    result_t head;

    assign accept = push && !full;

    vrr_deframer u_deframer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .rx_byte    (rx_byte),
        .frame_push (frame_push),
        .frame      (frame_in)
    );

    vrr_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (frame_push),
        .wr_data (frame_in),
        .full    (full),
        .rd_en   (frame_take),
        .rd_data (frame_out),
        .valid   (frame_valid)
    );

    vrr_classifier u_classifier
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame       (frame_out),
        .frame_take  (frame_take),
        .pop         (pop),
        .head_valid  (head_valid),
        .head        (head)
    );

    assign empty = !head_valid;
    assign reply_kind = head.kind;
    assign socket_number = head.sock;
    assign reply_length = head.len;
    assign error_byte = head.error_byte;
    assign first_value = head.value_one;
    assign second_value = head.value_two;
    assign socket_one_busy = head.busy[0];
    assign socket_two_busy = head.busy[1];

endmodule

/* rtl/vrr_deframer.sv */
module vrr_deframer
    import vrr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       frame_push,
    output frame_t     frame
);

    logic             in_packet_reg, in_packet_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       third_reg, third_next;
    logic [15:0]      v1_reg, v1_next;
    logic [15:0]      v2_reg, v2_next;

    logic [4:0]       pos5;
    logic [CNT_W:0]   len_full;
    logic [3:0]       nib;

    assign pos5 = 5'(count_reg);
    assign len_full = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign nib = rx_byte[3:0];

    always_comb
    begin
        frame_push = 1'b0;
        frame.has_type = (count_reg >= CNT_W'(2));
        frame.overlong = ovf_reg || (len_full > (CNT_W+1)'(MAX_REPLY_BYTES));
        frame.len = frame.overlong ? LEN_W'(MAX_REPLY_BYTES) : LEN_W'(len_full);
        frame.type_byte = type_reg;
        frame.third_byte = (count_reg == CNT_W'(2)) ? END_BYTE : third_reg;
        frame.value_one = v1_reg;
        frame.value_two = v2_reg;

        in_packet_next = in_packet_reg;
        count_next = count_reg;
        ovf_next = ovf_reg;
        type_next = type_reg;
        third_next = third_reg;
        v1_next = v1_reg;
        v2_next = v2_reg;

        if (accept)
        begin
            if (!in_packet_reg || rx_byte != END_BYTE)
            begin
                if ((!in_packet_reg || count_reg == CNT_W'(1)) && rx_byte == HDR_BYTE)
                begin
                    // start or restart a packet
                    in_packet_next = 1'b1;
                    count_next = CNT_W'(1);
                    ovf_next = 1'b0;
                    type_next = '0;
                    third_next = '0;
                    v1_next = '0;
                    v2_next = '0;
                end
                else if (in_packet_reg)
                begin
                    if (count_reg >= CNT_W'(MAX_REPLY_BYTES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + CNT_W'(1);
                        if (count_reg == CNT_W'(1))
                        begin
                            type_next = rx_byte;
                        end
                        if (count_reg == CNT_W'(2))
                        begin
                            third_next = rx_byte;
                        end
                        case (pos5)
                            5'd2:    v1_next[15:12] = nib;
                            5'd3:    v1_next[11:8] = nib;
                            5'd4:    v1_next[7:4] = nib;
                            5'd5:    v1_next[3:0] = nib;
                            5'd6:    v2_next[15:12] = nib;
                            5'd7:    v2_next[11:8] = nib;
                            5'd8:    v2_next[7:4] = nib;
                            5'd9:    v2_next[3:0] = nib;
                            default: ;
                        endcase
                    end
                end
            end
            else
            begin
                frame_push = 1'b1;
                in_packet_next = 1'b0;
                count_next = '0;
                ovf_next = 1'b0;
                third_next = frame.third_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet_reg <= 1'b0;
            count_reg <= '0;
            ovf_reg <= 1'b0;
            type_reg <= '0;
            third_reg <= '0;
            v1_reg <= '0;
            v2_reg <= '0;
        end
        else
        begin
            in_packet_reg <= in_packet_next;
            count_reg <= count_next;
            ovf_reg <= ovf_next;
            type_reg <= type_next;
            third_reg <= third_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

endmodule

/* rtl/vrr_queue.sv */
module vrr_queue
    import vrr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   wr_en,
    input  frame_t wr_data,
    output logic   full,
    input  logic   rd_en,
    output frame_t rd_data,
    output logic   valid
);

    frame_t            slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              do_wr, do_rd;

    assign full = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign rd_data = slot_reg[rd_ptr_reg];
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + QPTR_W'(1);
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + (QPTR_W+1)'(1);
            2'b01:   count_next = count_reg - (QPTR_W+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/vrr_classifier.sv */
module vrr_classifier
    import vrr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    frame_valid,
    input  frame_t  frame,
    output logic    frame_take,
    input  logic    pop,
    output logic    head_valid,
    output result_t head
);

    logic       head_valid_reg, head_valid_next;
    logic       skid_valid_reg, skid_valid_next;
    result_t    head_reg, head_next;
    result_t    skid_reg, skid_next;
    logic [1:0] pend_reg, pend_next;

    result_t    res;
    logic [3:0] hi;
    logic [1:0] sock_bit;
    logic       release_out;

    assign hi = frame.type_byte[7:4];
    assign frame_take = frame_valid && !skid_valid_reg;
    assign release_out = !head_valid_reg || pop;
    assign head_valid = head_valid_reg;
    assign head = head_reg;

    always_comb
    begin
        case (frame.type_byte[3:0])
            SOCK_ONE: sock_bit = 2'b01;
            SOCK_TWO: sock_bit = 2'b10;
            default:  sock_bit = 2'b00;
        endcase

        pend_next = pend_reg;
        if (frame.overlong)
        begin
            res.kind = KIND_OVERLONG;
        end
        else if (frame.has_type && hi == HI_ACK && frame.len == LEN_SHORT)
        begin
            res.kind = KIND_ACK;
            pend_next = pend_reg | sock_bit;
        end
        else if (frame.has_type && hi == HI_COMPLETION && frame.len == LEN_SHORT)
        begin
            res.kind = KIND_COMPLETION;
            pend_next = pend_reg & ~sock_bit;
        end
        else if (frame.has_type && frame.type_byte == TYPE_INFO)
        begin
            res.kind = KIND_INFO;
        end
        else if (frame.has_type && hi == HI_ERROR)
        begin
            res.kind = KIND_ERROR;
            if (frame.len == LEN_CANCEL && (frame.third_byte == ERR_CANCEL_A
                                            || frame.third_byte == ERR_CANCEL_B))
            begin
                pend_next = pend_reg & ~sock_bit;
            end
        end
        else
        begin
            res.kind = KIND_OTHER;
        end
        if (!frame_take)
        begin
            pend_next = pend_reg;
        end

        res.sock = frame.type_byte[3:0];
        res.len = frame.len;
        res.error_byte = frame.third_byte;
        res.value_one = frame.value_one;
        res.value_two = frame.value_two;
        res.busy = pend_next;

        // two-entry output stage: head on the ports, skid behind it
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        head_next = head_reg;
        skid_next = skid_reg;
        if (release_out)
        begin
            if (skid_valid_reg)
            begin
                head_next = skid_reg;
                head_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next = res;
                head_valid_next = frame_take;
            end
        end
        else if (frame_take)
        begin
            skid_next = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            pend_reg <= '0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

/* sim/tb_visca_reply_receiver.sv */
module tb_visca_reply_receiver;
    import vrr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] OPENING_BYTES [23] = '{
        8'h00, 8'hFF,
        8'h90, 8'h41, 8'hFF,
        8'h90, 8'h42, 8'hFF,
        8'h90, 8'h90, 8'h51, 8'hFF,
        8'h90, 8'h62, 8'h05, 8'hFF,
        8'h90, 8'hFF,
        8'h90, 8'h50, 8'hA3, 8'h5C, 8'hFF
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        rx_byte = 8'h00;
    logic              empty;
    logic              pop = 1'b0;
    logic [2:0]        reply_kind;
    logic [3:0]        socket_number;
    logic [LEN_W-1:0]  reply_length;
    logic [7:0]        error_byte;
    logic [15:0]       first_value;
    logic [15:0]       second_value;
    logic              socket_one_busy;
    logic              socket_two_busy;

    logic [7:0] byte_backlog [$];
    result_t    replies_due [$];
    bit         byte_taken = 1'b0;
    bit         steady = 1'b0;
    int         sent_count = 0;
    int         mismatch_count = 0;

    // deframer image
    bit          framing = 1'b0;
    logic [4:0]  frame_pos = '0;
    logic [7:0]  frame_type = '0;
    logic [7:0]  frame_third = '0;
    logic [15:0] frame_val_one = '0;
    logic [15:0] frame_val_two = '0;
    bit          frame_overlong = 1'b0;
    logic [1:0]  sockets_pending = '0;

    visca_reply_receiver u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .empty           (empty),
        .pop             (pop),
        .reply_kind      (reply_kind),
        .socket_number   (socket_number),
        .reply_length    (reply_length),
        .error_byte      (error_byte),
        .first_value     (first_value),
        .second_value    (second_value),
        .socket_one_busy (socket_one_busy),
        .socket_two_busy (socket_two_busy)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic open_frame();
        framing = 1'b1;
        frame_pos = 5'd1;
        frame_type = '0;
        frame_third = '0;
        frame_val_one = '0;
        frame_val_two = '0;
        frame_overlong = 1'b0;
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        int         pos;
        logic [4:0] len;
        logic [3:0] sock;
        logic [1:0] sel;
        result_t    r;
        if (!framing)
        begin
            if (b == HDR_BYTE)
                open_frame();
            return;
        end
        pos = int'(frame_pos);
        if (b != END_BYTE)
        begin
            if (pos == 1 && b == HDR_BYTE)
            begin
                open_frame();
                return;
            end
            if (pos >= MAX_REPLY_BYTES)
            begin
                frame_overlong = 1'b1;
                return;
            end
            if (pos == 1)
                frame_type = b;
            if (pos == 2)
                frame_third = b;
            if (pos >= 2 && pos <= 5)
                frame_val_one = frame_val_one | ({12'd0, b[3:0]} << (4 * (5 - pos)));
            if (pos >= 6 && pos <= 9)
                frame_val_two = frame_val_two | ({12'd0, b[3:0]} << (4 * (9 - pos)));
            frame_pos = 5'(pos + 1);
            return;
        end

        if (pos == 2)
            frame_third = END_BYTE;
        len = 5'(pos + 1);
        if (frame_overlong || len > MAX_REPLY_BYTES)
        begin
            frame_overlong = 1'b1;
            len = 5'(MAX_REPLY_BYTES);
        end
        sock = frame_type[3:0];
        sel = (sock == SOCK_ONE) ? 2'b01 : (sock == SOCK_TWO) ? 2'b10 : 2'b00;

        if (frame_overlong)
            r.kind = KIND_OVERLONG;
        else if (pos >= 2 && frame_type[7:4] == HI_ACK && len == LEN_SHORT)
        begin
            r.kind = KIND_ACK;
            sockets_pending = sockets_pending | sel;
        end
        else if (pos >= 2 && frame_type[7:4] == HI_COMPLETION && len == LEN_SHORT)
        begin
            r.kind = KIND_COMPLETION;
            sockets_pending = sockets_pending & ~sel;
        end
        else if (pos >= 2 && frame_type == TYPE_INFO)
            r.kind = KIND_INFO;
        else if (pos >= 2 && frame_type[7:4] == HI_ERROR)
        begin
            r.kind = KIND_ERROR;
            if (len == LEN_CANCEL && (frame_third == ERR_CANCEL_A || frame_third == ERR_CANCEL_B))
                sockets_pending = sockets_pending & ~sel;
        end
        else
            r.kind = KIND_OTHER;

        r.sock = sock;
        r.len = len;
        r.error_byte = frame_third;
        r.value_one = frame_val_one;
        r.value_two = frame_val_two;
        r.busy = sockets_pending;
        replies_due.push_back(r);

        framing = 1'b0;
        frame_pos = '0;
        frame_overlong = 1'b0;
    endtask

    function automatic void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // monitor: sample both handshakes at the rising edge
    always @(posedge clk)
    begin : monitor
        result_t due;
        byte_taken = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                byte_taken = 1'b1;
                absorb_byte(rx_byte);
            end
            if (pop && !empty)
            begin
                if (replies_due.size() == 0)
                begin
                    $display("%0t: reply beat with nothing expected, kind %0d", $time,
                             reply_kind);
                    mismatch_count++;
                end
                else
                begin
                    due = replies_due.pop_front();
                    compare_field("reply_kind", 16'(due.kind), 16'(reply_kind));
                    compare_field("socket_number", 16'(due.sock), 16'(socket_number));
                    compare_field("reply_length", 16'(due.len), 16'(reply_length));
                    compare_field("error_byte", 16'(due.error_byte), 16'(error_byte));
                    compare_field("first_value", due.value_one, first_value);
                    compare_field("second_value", due.value_two, second_value);
                    compare_field("socket_one_busy", 16'(due.busy[0]), 16'(socket_one_busy));
                    compare_field("socket_two_busy", 16'(due.busy[1]), 16'(socket_two_busy));
                end
            end
        end
    end

    // driver: advance on the falling edge, hold a beat until it is taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (byte_taken)
                sent_count++;
            steady = (sent_count >= 400 && sent_count < 700);
            if (!push || byte_taken)
            begin
                if (byte_backlog.size() > 0 && (steady || $urandom_range(99) >= 36))
                begin
                    rx_byte <= byte_backlog.pop_front();
                    push <= 1'b1;
                end
                else
                begin
                    rx_byte <= 8'($urandom);
                    push <= 1'b0;
                end
            end
            pop <= steady || ($urandom_range(99) >= 36);
        end
    end

    task automatic append_reply(input logic [7:0] type_b, input int extra, input bit cancel,
                                inout int framed);
        byte_backlog.push_back(HDR_BYTE);
        byte_backlog.push_back(type_b);
        for (int i = 0; i < extra; i++)
        begin
            if (i == 0 && cancel)
                byte_backlog.push_back($urandom_range(1) ? ERR_CANCEL_A : ERR_CANCEL_B);
            else
                byte_backlog.push_back(8'($urandom_range(254)));
        end
        byte_backlog.push_back(END_BYTE);
        framed += extra + 3;
    endtask

    initial
    begin
        int         framed;
        int         pick;
        logic [3:0] sock;
        framed = 0;
        foreach (OPENING_BYTES[i])
            byte_backlog.push_back(OPENING_BYTES[i]);

        while (framed < 1200)
        begin
            pick = $urandom_range(99);
            sock = ($urandom_range(3) != 0) ? 4'($urandom_range(2, 1)) : 4'($urandom_range(15));
            if (pick < 8)
            begin
                repeat ($urandom_range(3, 1))
                    byte_backlog.push_back(8'($urandom));
            end
            else if (pick < 25)
                append_reply({HI_ACK, sock}, 0, 1'b0, framed);
            else if (pick < 40)
                append_reply({HI_COMPLETION, sock}, 0, 1'b0, framed);
            else if (pick < 55)
                append_reply(TYPE_INFO, $urandom_range(10), 1'b0, framed);
            else if (pick < 70)
            begin
                if ($urandom_range(3) != 0)
                    append_reply({HI_ERROR, sock}, 1, 1'b1, framed);
                else
                    append_reply({HI_ERROR, sock}, $urandom_range(6), 1'b0, framed);
            end
            else if (pick < 80)
                append_reply(8'($urandom_range(254)), $urandom_range(12), 1'b0, framed);
            else if (pick < 87)
                append_reply(8'($urandom_range(254)), $urandom_range(20, 12), 1'b0, framed);
            else if (pick < 93)
            begin
                byte_backlog.push_back(HDR_BYTE);
                append_reply({4'($urandom_range(6, 4)), sock}, $urandom_range(2), 1'b0, framed);
            end
            else
            begin
                // drop the terminator so the next header lands inside the frame
                byte_backlog.push_back(HDR_BYTE);
                repeat ($urandom_range(5, 1))
                    byte_backlog.push_back(8'($urandom_range(254)));
            end
        end
        append_reply({HI_COMPLETION, SOCK_ONE}, 0, 1'b0, framed);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (byte_backlog.size() != 0 || push)
            @(posedge clk);
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("%0t: timeout, %0d replies still expected", $time, replies_due.size());
        $display("Simulation FAILED");
        $finish;
    end

endmodule
